/* src/order_preserving_dedup_defines.svh */
// Assertion macros shared by the checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ORDER_PRESERVING_DEDUP_DEFINES_SVH
`define ORDER_PRESERVING_DEDUP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OPD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("order_preserving_dedup: same-cycle property failed");

// Consequent must hold in the cycle after the antecedent.
`define OPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("order_preserving_dedup: next-cycle property failed");

`endif

/* src/opd_pkg.sv */
package opd_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 7;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [POS_W-1:0]          pos_t;

  // Work descriptor handed from the front end to the search engine.
  typedef struct packed {
    value_t value;
    logic   clear;   // empty the store before this value is searched
  } work_t;

endpackage

/* src/opd_if.sv */
interface opd_in_if;
  logic                 valid;
  logic                 ready;
  opd_pkg::value_t      value;
  logic                 start_of_list;

  modport source (output valid, output value, output start_of_list, input ready);
  modport sink   (input valid, input value, input start_of_list, output ready);
endinterface

interface opd_out_if;
  logic                 valid;
  logic                 ready;
  opd_pkg::value_t      value_out;
  logic                 is_first;
  opd_pkg::pos_t        unique_position;
  logic                 overflow;

  modport source (output valid, output value_out, output is_first,
                  output unique_position, output overflow, input ready);
  modport sink   (input valid, input value_out, input is_first,
                  input unique_position, input overflow, output ready);
endinterface

/* src/opd_ram.sv */
module opd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/opd_front.sv */
// Input stage: takes transfers from the input channel and turns each into a
// work descriptor for the queue.
module opd_front (
  input  logic           clk,
  input  logic           rst,
  opd_in_if.sink         in_ch,
  output logic           push_valid,
  input  logic           push_ready,
  output opd_pkg::work_t push_data
);

  logic           hold_valid;
  opd_pkg::work_t hold;

  assign in_ch.ready = !rst && (!hold_valid || push_ready);
  assign push_valid  = hold_valid;
  assign push_data   = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      hold_valid <= 1'b1;
    end else if (push_ready) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      hold.value <= in_ch.value;
      hold.clear <= in_ch.start_of_list;
    end
  end

endmodule

/* src/opd_queue.sv */
// Two-entry queue between the front end and the search engine.
module opd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  opd_pkg::work_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output opd_pkg::work_t pop_data
);

  opd_pkg::work_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

/* src/opd_back.sv */
// Search engine: scans the distinct store one entry per cycle through the
// RAM read port, then appends or reports and loads the output register.
module opd_back #(
  parameter int CAPACITY = 128
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  opd_pkg::work_t q_data,
  opd_out_if.source      out_ch
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = IDX_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t                       state;
  logic [CNT_W-1:0]             count;
  opd_pkg::work_t               cur;
  logic [CNT_W-1:0]             issue_idx;
  logic                         cmp_valid;
  logic [IDX_W-1:0]             cmp_idx;
  logic                         found;
  logic [IDX_W-1:0]             hit_idx;

  logic                         out_valid;
  opd_pkg::value_t              out_value;
  logic                         out_first;
  opd_pkg::pos_t                out_pos;
  logic                         out_ovf;

  logic [opd_pkg::VALUE_W-1:0]  rdata;
  logic                         out_free;
  logic                         match;
  logic                         last;
  logic                         rd_en;
  logic                         full;
  logic                         wr_en;

  assign out_free = !out_valid || out_ch.ready;
  assign q_ready  = (state == ST_IDLE);
  assign match    = cmp_valid && (rdata == cur.value);
  assign last     = cmp_valid && (({1'b0, cmp_idx} + CNT_W'(1)) == count);
  assign rd_en    = (state == ST_SCAN) && (issue_idx < count) && !match;
  assign full     = (count == CNT_W'(CAPACITY));
  assign wr_en    = (state == ST_FINISH) && out_free && !found && !full;

  opd_ram #(
    .WIDTH (opd_pkg::VALUE_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count[IDX_W-1:0]),
    .wdata (cur.value),
    .re    (rd_en),
    .raddr (issue_idx[IDX_W-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      cmp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready && !((state == ST_FINISH) && out_free)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cmp_valid <= 1'b0;
            found     <= 1'b0;
            issue_idx <= '0;
            cur       <= q_data;
            if (q_data.clear) begin
              count <= '0;
            end
            if (q_data.clear || (count == '0)) begin
              state <= ST_FINISH;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          cmp_valid <= rd_en;
          cmp_idx   <= issue_idx[IDX_W-1:0];
          if (rd_en) begin
            issue_idx <= issue_idx + CNT_W'(1);
          end
          if (match) begin
            found   <= 1'b1;
            hit_idx <= cmp_idx;
            state   <= ST_FINISH;
          end else if (last) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          cmp_valid <= 1'b0;
          if (out_free) begin
            out_valid <= 1'b1;
            out_value <= cur.value;
            out_first <= !found && !full;
            out_ovf   <= !found && full;
            if (found) begin
              out_pos <= opd_pkg::POS_W'(hit_idx);
            end else if (full) begin
              out_pos <= '0;
            end else begin
              out_pos <= opd_pkg::POS_W'(count);
            end
            if (wr_en) begin
              count <= count + CNT_W'(1);
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.value_out       = out_value;
  assign out_ch.is_first        = out_first;
  assign out_ch.unique_position = out_pos;
  assign out_ch.overflow        = out_ovf;

endmodule

/* src/order_preserving_dedup.sv */
// Streaming duplicate removal that keeps the first occurrence of each signed
// 32-bit value, in order. Every input transfer yields exactly one output
// transfer: the value echoed back, is_first when it was appended to the store
// of distinct values, unique_position giving its place in the deduplicated
// list (or the place of its earlier occurrence for a repeat, low 7 bits only
// when CAPACITY exceeds 128), and overflow when the value is new but the
// store already holds CAPACITY values. A set start_of_list empties the store
// before its value is handled. The search engine takes one item at a time
// and scans the store RAM through its single read port, one entry per
// cycle, comparing a new value with every stored value and stopping at
// the first match for a repeat. An item with start_of_list set, or
// arriving on an empty store, skips the scan. A finished result waits
// while the output register is full. No clearing pass is needed after
// reset: only entries below the fill count are ever read.
module order_preserving_dedup #(
  parameter int CAPACITY = 128
) (
  input  logic      clk,
  input  logic      rst,
  opd_in_if.sink    in_ch,
  opd_out_if.source out_ch
);

  // Front end to queue.
  logic           push_valid;
  logic           push_ready;
  opd_pkg::work_t push_data;

  // Queue to search engine.
  logic           pop_valid;
  logic           pop_ready;
  opd_pkg::work_t pop_data;

  // The front end registers each input transfer into a work descriptor.
  opd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // The queue lets the input side keep taking transfers while the engine
  // scans the store.
  opd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // The engine owns the store and the fill count, and its output register
  // holds a finished result until the sink takes it.
  opd_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (pop_valid),
    .q_ready (pop_ready),
    .q_data  (pop_data),
    .out_ch  (out_ch)
  );

endmodule

/* src/opd_checker.sv */
`include "order_preserving_dedup_defines.svh"

module opd_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input opd_pkg::value_t out_value,
  input logic            out_first,
  input opd_pkg::pos_t   out_pos,
  input logic            out_ovf
);

  // Items accepted but not yet delivered; the design holds at most five.
  logic [3:0] pending;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_xfer && !out_xfer) begin
      pending <= pending + 4'd1;
    end else if (out_xfer && !in_xfer) begin
      pending <= pending - 4'd1;
    end
  end

  `OPD_ASSERT_SAME(a_no_invented_result, out_valid, pending != 4'd0)
  `OPD_ASSERT_SAME(a_overflow_position, out_valid && out_ovf, !out_first && (out_pos == '0))
  `OPD_ASSERT_NEXT(a_out_valid_holds, out_valid && !out_ready, out_valid)
  `OPD_ASSERT_NEXT(a_out_value_holds, out_valid && !out_ready, $stable(out_value))

endmodule

bind order_preserving_dedup opd_checker u_opd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.value_out),
  .out_first (out_ch.is_first),
  .out_pos   (out_ch.unique_position),
  .out_ovf   (out_ch.overflow)
);
